// ===== rtl/core/csvft_pkg.sv =====
// Shared types and constants of the CSV field tokenizer.
`default_nettype none

package csvft_pkg;

  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;

  // register indexes, byte address is 4 times the index
  localparam logic [1:0] REG_DELIM     = 2'd0;
  localparam logic [1:0] REG_SKIP_ROWS = 2'd1;
  localparam logic [1:0] REG_SKIP_EMPTY = 2'd2;
  localparam logic [1:0] REG_HEADER    = 2'd3;

  localparam logic [BYTE_W-1:0] DELIM_RST = 8'd44;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ROW_END   = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic              ovf;
  } pend_tok_t;

endpackage

`default_nettype wire

// ===== rtl/core/csv_field_tokenizer.sv =====
// Streaming CSV tokenizer top level: byte in, field bytes and field/row ends out.
//
// Input words carry one content byte in in_tdata and the end-of-text mark in
// in_tlast. Each output word is one token: out_tuser holds its
// kind (data byte, field end, row end), out_tdata its byte, column, row index
// and flags, out_tlast marks the last token caused by one input word.
// The block takes one input word at a time: accept in ST_IDLE, decode in
// ST_BYTE, then a single data byte or field end from ST_DATA. Held trailing
// spaces are flushed first: the flush walks the space buffer one entry a
// cycle, while the output register is free, through its single read port.
// A line end is decided in ST_LINE; field end (if kept) and row end follow.
// in_tready is high only while the sequencer is idle; the last token of a
// word may still sit in the output register while the next word is taken.
// A stalled receiver holds the output register and the sequencer waits.
// Synchronous reset clears all counters, the header and column-limit state,
// and loads the register reset values; the space buffer needs no clearing.
// Registers on the APB port: delimiter, rows to skip, skip empty lines,
// first row is header, at byte addresses 0, 4, 8 and 12.
`default_nettype none

module csv_field_tokenizer
  import csvft_pkg::*;
#(
  parameter int SPACE_DEPTH = 32,
  parameter int MAX_COLUMNS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_text
  // token stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [7:0] field_byte, [15:8] column_index,
                                       // [47:16] row_index, [48] header_row,
                                       // [49] overflow_flag, [55:50] zero
  output logic [1:0]       out_tuser,  // [1:0] token_kind
  output logic             out_tlast,  // last_of_run
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int SC_W  = $clog2(SPACE_DEPTH + 2);
  localparam int IDX_W = SPACE_DEPTH > 1 ? $clog2(SPACE_DEPTH) : 1;

  localparam logic [COL_W-1:0] COL_MAX  = COL_W'(MAX_COLUMNS);
  localparam logic [COL_W:0]   COL_MAXW = (COL_W + 1)'(MAX_COLUMNS);
  localparam logic [SC_W-1:0]  SC_DEPTH = SC_W'(SPACE_DEPTH);
  localparam logic [SC_W-1:0]  SC_OVER  = SC_W'(SPACE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_FLUSH,
    ST_DATA,
    ST_LINE,
    ST_FEND,
    ST_ROWEND
  } state_t;

  // configuration registers
  logic [7:0]  delim_r;
  logic [15:0] rows_to_skip_r;
  logic        skip_empty_r;
  logic        first_hdr_r;
  logic        cfg_wr;

  // sequencer and tokenizer state
  state_t             state_r, state_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               eot_r, eot_nxt;
  logic [15:0]        lines_seen_r, lines_seen_nxt;
  logic               in_quoted_r, in_quoted_nxt;
  logic               qp_r, qp_nxt;
  logic               fhc_r, fhc_nxt;
  logic               lhb_r, lhb_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [SC_W-1:0]    sc_r, sc_nxt;
  logic               hdr_taken_r, hdr_taken_nxt;
  logic [COL_W-1:0]   col_limit_r, col_limit_nxt;
  logic               limit_known_r, limit_known_nxt;
  logic [31:0]        data_rows_r, data_rows_nxt;
  pend_tok_t          pend_r, pend_nxt;
  logic [SC_W-1:0]    fl_cnt_r, fl_cnt_nxt;
  logic [SC_W-1:0]    fl_n_r, fl_n_nxt;
  logic               fl_ovf_r, fl_ovf_nxt;
  logic               line_go_r, line_go_nxt;
  logic               line_emit_r, line_emit_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  tok_kind_t          out_kind_r, out_kind_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic [7:0]         out_col_r, out_col_nxt;
  logic [31:0]        out_row_r, out_row_nxt;
  logic               out_hdr_r, out_hdr_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_last_r, out_last_nxt;

  // token to load this cycle
  logic               tok_load;
  tok_kind_t          tok_kind;
  logic [7:0]         tok_byte;
  logic [COL_W-1:0]   tok_col;
  logic               tok_ovf;
  logic               tok_last;

  // decode of the held byte
  logic               is_nl, is_ws, active, in_q_eff, is_dq, is_quote, is_delim, is_data;
  logic               kept, out_free, sc_over, lhb_after;
  logic [COL_W:0]     col_plus;
  logic               buf_we;
  logic [IDX_W-1:0]   buf_waddr, buf_raddr;
  logic [7:0]         buf_rdata;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r        <= DELIM_RST;
      rows_to_skip_r <= '0;
      skip_empty_r   <= 1'b1;
      first_hdr_r    <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_DELIM:      delim_r        <= cfg_pwdata[7:0];
        REG_SKIP_ROWS:  rows_to_skip_r <= cfg_pwdata[15:0];
        REG_SKIP_EMPTY: skip_empty_r   <= cfg_pwdata[0];
        REG_HEADER:     first_hdr_r    <= cfg_pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_DELIM:      cfg_prdata = {24'd0, delim_r};
      REG_SKIP_ROWS:  cfg_prdata = {16'd0, rows_to_skip_r};
      REG_SKIP_EMPTY: cfg_prdata = {31'd0, skip_empty_r};
      REG_HEADER:     cfg_prdata = {31'd0, first_hdr_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- space buffer ----------------
  assign buf_waddr = sc_r[IDX_W-1:0];
  assign buf_raddr = fl_cnt_nxt[IDX_W-1:0];

  csvft_space_buf #(
    .DEPTH (SPACE_DEPTH)
  ) u_space_buf (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (buf_waddr),
    .wr_data (byte_r),
    .rd_addr (buf_raddr),
    .rd_data (buf_rdata)
  );

  // ---------------- byte decode ----------------
  assign is_nl    = (byte_r == CH_NL);
  assign is_ws    = (byte_r == CH_SP) || (byte_r == CH_TAB) || (byte_r == CH_CR) || is_nl;
  assign active   = !is_nl && (lines_seen_r >= rows_to_skip_r);
  assign in_q_eff = qp_r ? 1'b0 : in_quoted_r;
  assign is_dq    = qp_r && (byte_r == CH_QUOTE);
  assign is_quote = !is_dq && (byte_r == CH_QUOTE);
  assign is_delim = !is_dq && (byte_r != CH_QUOTE) && (byte_r == delim_r) && !in_q_eff;
  assign is_data  = !is_quote && !is_delim;
  assign kept     = (col_r < COL_MAX) && (!limit_known_r || (col_r < col_limit_r));
  assign sc_over  = (sc_r > SC_DEPTH);
  assign lhb_after = is_nl ? lhb_r : 1'b1;
  assign col_plus = {1'b0, col_r} + (COL_W + 1)'(1);
  assign out_free = !out_valid_r || out_tready;

  assign in_tready = (state_r == ST_IDLE);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt       = state_r;
    byte_nxt        = byte_r;
    eot_nxt         = eot_r;
    lines_seen_nxt  = lines_seen_r;
    in_quoted_nxt   = in_quoted_r;
    qp_nxt          = qp_r;
    fhc_nxt         = fhc_r;
    lhb_nxt         = lhb_r;
    col_nxt         = col_r;
    sc_nxt          = sc_r;
    hdr_taken_nxt   = hdr_taken_r;
    col_limit_nxt   = col_limit_r;
    limit_known_nxt = limit_known_r;
    data_rows_nxt   = data_rows_r;
    pend_nxt        = pend_r;
    fl_cnt_nxt      = fl_cnt_r;
    fl_n_nxt        = fl_n_r;
    fl_ovf_nxt      = fl_ovf_r;
    line_go_nxt     = line_go_r;
    line_emit_nxt   = line_emit_r;
    buf_we          = 1'b0;

    tok_load = 1'b0;
    tok_kind = KIND_DATA;
    tok_byte = '0;
    tok_col  = col_r;
    tok_ovf  = 1'b0;
    tok_last = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          byte_nxt  = in_tdata;
          eot_nxt   = in_tlast;
          state_nxt = ST_BYTE;
        end
      end

      ST_BYTE: begin
        line_go_nxt   = is_nl || eot_r;
        line_emit_nxt = (is_nl || eot_r) && (lines_seen_r >= rows_to_skip_r)
                        && (lhb_after || !skip_empty_r);
        state_nxt = (is_nl || eot_r) ? ST_LINE : ST_IDLE;
        if (!is_nl) begin
          lhb_nxt = 1'b1;
        end
        if (active) begin
          qp_nxt = is_quote && in_q_eff;
          if (is_quote) begin
            in_quoted_nxt = 1'b1;
          end else if (qp_r && !is_dq) begin
            in_quoted_nxt = 1'b0;
          end
          if (is_delim) begin
            if (kept) begin
              pend_nxt  = '{kind: KIND_FIELD_END, data: '0, ovf: 1'b0};
              state_nxt = ST_DATA;
            end
            fhc_nxt = 1'b0;
            sc_nxt  = '0;
            if (col_r < COL_MAX) begin
              col_nxt = col_r + COL_W'(1);
            end
          end else if (is_data && kept) begin
            if (!fhc_r) begin
              // drop leading whitespace
              if (!is_ws) begin
                fhc_nxt   = 1'b1;
                pend_nxt  = '{kind: KIND_DATA, data: byte_r, ovf: 1'b0};
                state_nxt = ST_DATA;
              end
            end else if (is_ws) begin
              // hold trailing whitespace, mark overflow once full
              if (sc_r < SC_DEPTH) begin
                buf_we = 1'b1;
                sc_nxt = sc_r + SC_W'(1);
              end else begin
                sc_nxt = SC_OVER;
              end
            end else begin
              pend_nxt  = '{kind: KIND_DATA, data: byte_r, ovf: sc_over};
              state_nxt = ST_DATA;
              sc_nxt    = '0;
              if (sc_r != '0) begin
                fl_cnt_nxt = '0;
                fl_n_nxt   = sc_over ? SC_DEPTH : sc_r;
                fl_ovf_nxt = sc_over;
                state_nxt  = ST_FLUSH;
              end
            end
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          tok_load = 1'b1;
          tok_kind = KIND_DATA;
          tok_byte = buf_rdata;
          tok_ovf  = fl_ovf_r;
          fl_cnt_nxt = fl_cnt_r + SC_W'(1);
          if (fl_cnt_r + SC_W'(1) == fl_n_r) begin
            state_nxt = ST_DATA;
          end
        end
      end

      ST_DATA: begin
        if (out_free) begin
          tok_load  = 1'b1;
          tok_kind  = pend_r.kind;
          tok_byte  = pend_r.data;
          tok_ovf   = pend_r.ovf;
          // a delimiter has already advanced the column past its field
          tok_col   = (pend_r.kind == KIND_FIELD_END) ? col_r - COL_W'(1) : col_r;
          tok_last  = !line_emit_r;
          state_nxt = line_go_r ? ST_LINE : ST_IDLE;
        end
      end

      ST_LINE: begin
        if (line_emit_r) begin
          state_nxt = kept ? ST_FEND : ST_ROWEND;
        end else begin
          if (lines_seen_r < rows_to_skip_r) begin
            lines_seen_nxt = lines_seen_r + 16'd1;
          end
          in_quoted_nxt = 1'b0;
          qp_nxt        = 1'b0;
          fhc_nxt       = 1'b0;
          sc_nxt        = '0;
          col_nxt       = '0;
          lhb_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_FEND: begin
        if (out_free) begin
          tok_load  = 1'b1;
          tok_kind  = KIND_FIELD_END;
          state_nxt = ST_ROWEND;
        end
      end

      ST_ROWEND: begin
        if (out_free) begin
          tok_load = 1'b1;
          tok_kind = KIND_ROW_END;
          tok_col  = '0;
          tok_ovf  = (col_r >= COL_MAX);
          tok_last = 1'b1;
          if (first_hdr_r && !hdr_taken_r) begin
            hdr_taken_nxt = 1'b1;
          end else begin
            data_rows_nxt = data_rows_r + 32'd1;
            if (lines_seen_r != 16'hFFFF) begin
              lines_seen_nxt = lines_seen_r + 16'd1;
            end
          end
          if (!limit_known_r) begin
            col_limit_nxt   = (col_plus > COL_MAXW) ? COL_MAX : col_plus[COL_W-1:0];
            limit_known_nxt = 1'b1;
          end
          in_quoted_nxt = 1'b0;
          qp_nxt        = 1'b0;
          fhc_nxt       = 1'b0;
          sc_nxt        = '0;
          col_nxt       = '0;
          lhb_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_hdr_nxt   = out_hdr_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    if (tok_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = tok_kind;
      out_byte_nxt  = tok_byte;
      out_col_nxt   = 8'(tok_col);
      out_row_nxt   = data_rows_r;
      out_hdr_nxt   = first_hdr_r && !hdr_taken_r;
      out_ovf_nxt   = tok_ovf;
      out_last_nxt  = tok_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      lines_seen_r  <= '0;
      in_quoted_r   <= 1'b0;
      qp_r          <= 1'b0;
      fhc_r         <= 1'b0;
      lhb_r         <= 1'b0;
      col_r         <= '0;
      sc_r          <= '0;
      hdr_taken_r   <= 1'b0;
      col_limit_r   <= '0;
      limit_known_r <= 1'b0;
      data_rows_r   <= '0;
      fl_cnt_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      lines_seen_r  <= lines_seen_nxt;
      in_quoted_r   <= in_quoted_nxt;
      qp_r          <= qp_nxt;
      fhc_r         <= fhc_nxt;
      lhb_r         <= lhb_nxt;
      col_r         <= col_nxt;
      sc_r          <= sc_nxt;
      hdr_taken_r   <= hdr_taken_nxt;
      col_limit_r   <= col_limit_nxt;
      limit_known_r <= limit_known_nxt;
      data_rows_r   <= data_rows_nxt;
      fl_cnt_r      <= fl_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      byte_r        <= byte_nxt;
      eot_r         <= eot_nxt;
      pend_r        <= pend_nxt;
      fl_n_r        <= fl_n_nxt;
      fl_ovf_r      <= fl_ovf_nxt;
      line_go_r     <= line_go_nxt;
      line_emit_r   <= line_emit_nxt;
      out_kind_r    <= out_kind_nxt;
      out_byte_r    <= out_byte_nxt;
      out_col_r     <= out_col_nxt;
      out_row_r     <= out_row_nxt;
      out_hdr_r     <= out_hdr_nxt;
      out_ovf_r     <= out_ovf_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_ovf_r, out_hdr_r, out_row_r, out_col_r, out_byte_r};

  // ---------------- assertions ----------------
  a_sc_bound : assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= SC_OVER)
    else $error("space count beyond overflow mark");

  a_col_bound : assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_MAX)
    else $error("column counter beyond limit");

  a_row_end_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_ROW_END)) |-> out_tlast)
    else $error("row end is not the last token of its word");

  a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while decoding");

endmodule

`default_nettype wire

// ===== rtl/core/csvft_space_buf.sv =====
// Trailing whitespace buffer: one write port, one registered read port.
`default_nettype none

module csvft_space_buf
  import csvft_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [BYTE_W-1:0]                   wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [BYTE_W-1:0]                   rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
